// ----- hw/rtl/eptc_pkg.sv -----
`timescale 1ns / 1ps
package eptc_pkg;

  // seconds per day split as 675 << 7
  localparam logic [9:0]  SECS_DAY_HI     = 10'd675;
  localparam logic [24:0] RECIP_675       = 25'd25451658;  // floor(2^34 / 675)
  localparam logic [5:0]  SIXTY           = 6'd60;
  localparam logic [16:0] RECIP_15        = 17'd69905;     // floor(2^20 / 15)
  localparam logic [2:0]  DAYS_PER_WEEK   = 3'd7;
  localparam logic [17:0] RECIP_7         = 18'd149796;    // floor(2^20 / 7)
  localparam logic [2:0]  EPOCH_WEEKDAY   = 3'd4;
  localparam logic [19:0] EPOCH_SHIFT     = 20'd719468;
  localparam logic [19:0] ERA5_START      = 20'd730485;
  localparam logic [19:0] ERA4_START      = 20'd584388;
  localparam logic [17:0] LAST_DOE        = 18'd146096;
  localparam logic [8:0]  DAYS_PER_YEAR   = 9'd365;
  localparam logic [15:0] RECIP_365_S24   = 16'd45964;     // floor(2^24 / 365)
  localparam logic [13:0] CENT_DAYS_Q     = 14'd9131;      // 36524 >> 2
  localparam logic [16:0] RECIP_9131      = 17'd117593;    // floor(2^30 / 9131)
  localparam logic [17:0] RECIP_365_S26   = 18'd183859;    // floor(2^26 / 365)
  localparam logic [10:0] YEAR_ERA4       = 11'd1600;
  localparam logic [10:0] YEAR_ERA5       = 11'd2000;
  localparam logic [3:0]  MP_JANUARY      = 4'd10;
  localparam logic [3:0]  MONTHS_PER_YEAR = 4'd12;

  typedef struct packed {
    logic [14:0] days;
    logic [16:0] sod;
  } split_t;

  typedef struct packed {
    logic [14:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } hms_t;

  typedef struct packed {
    logic [10:0] year_number;
    logic [3:0]  month_of_year;
    logic [2:0]  day_of_week;
    logic [4:0]  month_day;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } result_t;

  // first day of each month in a year that starts on march 1
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/epoch_seconds_to_calendar.sv -----
`timescale 1ns / 1ps
// channel   dir  payload                                         handshake
// s_axis    in   tdata[30:0] epoch_seconds                       tvalid/tready
// m_axis    out  tdata[39:0] sec, min, hour, mday, wday, mon, yr  tvalid/tready
//
// one transfer in and one out per cycle, sustained while m_axis_tready stays high
// the pipeline first splits days from seconds of day, then works out the time
// of day, then the calendar date; most stages are a reciprocal multiply
// or the correction step that follows it, the rest compare and add
// rst clears only the stage valid bits
// a stall at m_axis holds the last stage; earlier stages keep filling bubbles
module epoch_seconds_to_calendar (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [30:0] epoch_seconds
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [21:17] day of month, [24:22] day_of_week, [28:25] month_of_year,
  // [39:29] year_number
  output logic [39:0] m_axis_tdata
);
  import eptc_pkg::*;

  split_t  split_data;
  logic    split_valid;
  logic    split_ready;
  hms_t    hms_data;
  logic    hms_valid;
  logic    hms_ready;
  result_t res;

  eptc_split u_split (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .secs      (s_axis_tdata[30:0]),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  eptc_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (hms_valid),
    .out_ready (hms_ready),
    .out_data  (hms_data)
  );

  eptc_date u_date (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (hms_valid),
    .in_ready  (hms_ready),
    .in_data   (hms_data),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (res)
  );

  assign m_axis_tdata = res;

endmodule

// ----- hw/rtl/eptc_split.sv -----
`timescale 1ns / 1ps
module eptc_split (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [30:0]           secs,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eptc_pkg::split_t      out_data
);
  import eptc_pkg::*;

  localparam int NSTG = 3;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  logic [23:0] s1_x;
  logic [6:0]  s1_lo;
  logic [48:0] s1_prod;
  logic [14:0] s2_q;
  logic [10:0] s2_r;
  logic [6:0]  s2_lo;
  logic [14:0] s3_days;
  logic [16:0] s3_sod;

  logic [14:0] q0;
  logic [24:0] rem_full;
  logic        over;
  logic [10:0] rem_sub;
  logic [10:0] rem_adj;

  // secs >> 7 divided by 675 gives whole days
  assign q0       = s1_prod[48:34];
  assign rem_full = 25'(s1_x) - 25'(q0) * 25'(SECS_DAY_HI);
  assign over     = s2_r >= 11'(SECS_DAY_HI);
  assign rem_sub  = s2_r - 11'(SECS_DAY_HI);
  assign rem_adj  = over ? rem_sub : s2_r;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_x    <= secs[30:7];
      s1_lo   <= secs[6:0];
      s1_prod <= 49'(secs[30:7]) * 49'(RECIP_675);
    end
    if (en[1]) begin
      s2_q  <= q0;
      s2_r  <= rem_full[10:0];
      s2_lo <= s1_lo;
    end
    if (en[2]) begin
      s3_days <= s2_q + 15'(over);
      s3_sod  <= {rem_adj[9:0], s2_lo};
    end
  end

  assign out_data.days = s3_days;
  assign out_data.sod  = s3_sod;

endmodule

// ----- hw/rtl/eptc_clock.sv -----
`timescale 1ns / 1ps
module eptc_clock (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eptc_pkg::split_t      in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eptc_pkg::hms_t        out_data
);
  import eptc_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  logic [14:0] days_q [0:NSTG-1];
  logic [31:0] c1_prod;
  logic [16:0] c1_sod;
  logic [10:0] c2_mt;
  logic [6:0]  c2_rr;
  logic [10:0] c3_mt;
  logic [5:0]  c3_sec;
  logic [25:0] c4_prod;
  logic [10:0] c4_mt;
  logic [5:0]  c4_sec;
  logic [4:0]  c5_h;
  logic [6:0]  c5_rr;
  logic [5:0]  c5_sec;
  logic [4:0]  c6_hour;
  logic [5:0]  c6_min;
  logic [5:0]  c6_sec;

  logic [10:0] mt0;
  logic [16:0] diff1;
  logic        over1;
  logic [6:0]  rr1_sub;
  logic [4:0]  h0;
  logic [10:0] diff2;
  logic        over2;
  logic [6:0]  rr2_sub;

  // minutes of day: (sod >> 2) / 15
  assign mt0     = c1_prod[30:20];
  assign diff1   = c1_sod - 17'(mt0) * 17'(SIXTY);
  assign over1   = c2_rr >= 7'(SIXTY);
  assign rr1_sub = c2_rr - 7'(SIXTY);
  // hours: (minutes >> 2) / 15
  assign h0      = c4_prod[24:20];
  assign diff2   = c4_mt - 11'(h0) * 11'(SIXTY);
  assign over2   = c5_rr >= 7'(SIXTY);
  assign rr2_sub = c5_rr - 7'(SIXTY);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      days_q[0] <= in_data.days;
      c1_sod    <= in_data.sod;
      c1_prod   <= 32'(in_data.sod[16:2]) * 32'(RECIP_15);
    end
    for (int i = 1; i < NSTG; i++) begin
      if (en[i]) days_q[i] <= days_q[i-1];
    end
    if (en[1]) begin
      c2_mt <= mt0;
      c2_rr <= diff1[6:0];
    end
    if (en[2]) begin
      c3_mt  <= c2_mt + 11'(over1);
      c3_sec <= over1 ? rr1_sub[5:0] : c2_rr[5:0];
    end
    if (en[3]) begin
      c4_prod <= 26'(c3_mt[10:2]) * 26'(RECIP_15);
      c4_mt   <= c3_mt;
      c4_sec  <= c3_sec;
    end
    if (en[4]) begin
      c5_h   <= h0;
      c5_rr  <= diff2[6:0];
      c5_sec <= c4_sec;
    end
    if (en[5]) begin
      c6_hour <= c5_h + 5'(over2);
      c6_min  <= over2 ? rr2_sub[5:0] : c5_rr[5:0];
      c6_sec  <= c5_sec;
    end
  end

  assign out_data.days   = days_q[NSTG-1];
  assign out_data.hour   = c6_hour;
  assign out_data.minute = c6_min;
  assign out_data.sec    = c6_sec;

  a_hour_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> c6_hour < 5'd24)
    else $error("hour out of range");

  a_min_sec_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (c6_min < SIXTY) && (c6_sec < SIXTY))
    else $error("minute or second out of range");

endmodule

// ----- hw/rtl/eptc_date.sv -----
`timescale 1ns / 1ps
module eptc_date (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  eptc_pkg::hms_t        in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output eptc_pkg::result_t     out_data
);
  import eptc_pkg::*;

  localparam int NSTG = 10;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld[NSTG-1] || out_ready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  // values carried down the pipe
  hms_t        hms_q  [0:8];
  logic        era5_q [0:8];
  logic [2:0]  dow_q  [1:8];
  logic [17:0] doe_q  [0:6];
  logic [8:0]  yoe_q  [6:8];

  logic [14:0] d1_w;
  logic [32:0] d1_wprod;
  logic [31:0] d2_p1;
  logic [32:0] d2_p2;
  logic        d2_n3;
  logic [6:0]  d3_n1;
  logic [2:0]  d3_n2;
  logic        d3_n3;
  logic [17:0] d4_t;
  logic [35:0] d5_pt;
  logic [17:0] d5_t;
  logic [8:0]  d6_yoe0;
  logic [9:0]  d6_rt;
  logic [8:0]  d8_doy;
  logic [8:0]  d9_doy;
  logic [3:0]  d9_mp;
  result_t     res_q;

  // stage 1: shift to a march-based day count, pick the 400-year era and form the weekday sum
  logic [19:0] z;
  logic        era5;
  logic [19:0] doe_full;
  logic [14:0] wsum;
  assign z        = 20'(in_data.days) + EPOCH_SHIFT;
  assign era5     = z >= ERA5_START;
  assign doe_full = z - (era5 ? ERA5_START : ERA4_START);
  assign wsum     = in_data.days + 15'(EPOCH_WEEKDAY);

  // stage 2: weekday and reciprocal products for doe / 1460, doe / 36524
  logic [15:0] c2;
  logic [11:0] q7;
  logic [14:0] r7_full;
  logic [3:0]  r7;
  logic [3:0]  r7_sub;
  logic [2:0]  dow;
  assign c2      = doe_q[0][17:2];
  assign q7      = d1_wprod[31:20];
  assign r7_full = d1_w - 15'(q7) * 15'(DAYS_PER_WEEK);
  assign r7      = r7_full[3:0];
  assign r7_sub  = r7 - 4'(DAYS_PER_WEEK);
  assign dow     = (r7 >= 4'(DAYS_PER_WEEK)) ? r7_sub[2:0] : r7[2:0];

  // stage 3: correct the two quotients
  logic [15:0] c3;
  logic [6:0]  n1_0;
  logic [15:0] r1_full;
  logic [2:0]  n2_0;
  logic [15:0] r2_full;
  assign c3      = doe_q[1][17:2];
  assign n1_0    = d2_p1[30:24];
  assign r1_full = c3 - 16'(n1_0) * 16'(DAYS_PER_YEAR);
  assign n2_0    = d2_p2[32:30];
  assign r2_full = c3 - 16'(n2_0) * 16'(CENT_DAYS_Q);

  // stage 6: year of era, rough quotient and remainder
  logic [8:0]  yoe0;
  logic [17:0] rt_full;
  assign yoe0    = d5_pt[34:26];
  assign rt_full = d5_t - 18'(yoe0) * 18'(DAYS_PER_YEAR);

  // stage 8: day of the march-based year
  logic [1:0]  cent;
  logic [17:0] doy_full;
  assign cent = 2'(yoe_q[6] >= 9'd100) + 2'(yoe_q[6] >= 9'd200) + 2'(yoe_q[6] >= 9'd300);
  assign doy_full = doe_q[6] - 18'(yoe_q[6]) * 18'(DAYS_PER_YEAR)
                  - 18'(yoe_q[6][8:2]) + 18'(cent);

  // stage 9: month index by comparing against month starts
  logic [3:0] mp;
  always_comb begin
    mp = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (d8_doy >= month_start(4'(i))) mp = mp + 4'd1;
    end
  end

  // stage 10: final fields
  logic [8:0]  dom_full;
  logic        jan_feb;
  logic [3:0]  mon;
  logic [10:0] year;
  assign dom_full = d9_doy - month_start(d9_mp) + 9'd1;
  assign jan_feb  = d9_mp >= MP_JANUARY;
  assign mon      = jan_feb ? (d9_mp - 4'd9) : (d9_mp + 4'd3);
  assign year     = 11'(yoe_q[8]) + (era5_q[8] ? YEAR_ERA5 : YEAR_ERA4) + 11'(jan_feb);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hms_q[0]  <= in_data;
      era5_q[0] <= era5;
      doe_q[0]  <= doe_full[17:0];
      d1_w      <= wsum;
      d1_wprod  <= 33'(wsum) * 33'(RECIP_7);
    end
    for (int i = 1; i < 9; i++) begin
      if (en[i]) begin
        hms_q[i]  <= hms_q[i-1];
        era5_q[i] <= era5_q[i-1];
      end
    end
    for (int i = 1; i < 7; i++) begin
      if (en[i]) doe_q[i] <= doe_q[i-1];
    end
    for (int i = 2; i < 9; i++) begin
      if (en[i]) dow_q[i] <= dow_q[i-1];
    end
    for (int i = 7; i < 9; i++) begin
      if (en[i]) yoe_q[i] <= yoe_q[i-1];
    end
    if (en[1]) begin
      dow_q[1] <= dow;
      d2_p1    <= 32'(c2) * 32'(RECIP_365_S24);
      d2_p2    <= 33'(c2) * 33'(RECIP_9131);
      d2_n3    <= doe_q[0] == LAST_DOE;
    end
    if (en[2]) begin
      d3_n1 <= n1_0 + 7'(r1_full[9:0] >= 10'(DAYS_PER_YEAR));
      d3_n2 <= n2_0 + 3'(r2_full[14:0] >= 15'(CENT_DAYS_Q));
      d3_n3 <= d2_n3;
    end
    if (en[3]) begin
      d4_t <= doe_q[2] - 18'(d3_n1) + 18'(d3_n2) - 18'(d3_n3);
    end
    if (en[4]) begin
      d5_pt <= 36'(d4_t) * 36'(RECIP_365_S26);
      d5_t  <= d4_t;
    end
    if (en[5]) begin
      d6_yoe0 <= yoe0;
      d6_rt   <= rt_full[9:0];
    end
    if (en[6]) begin
      yoe_q[6] <= d6_yoe0 + 9'(d6_rt >= 10'(DAYS_PER_YEAR));
    end
    if (en[7]) begin
      d8_doy <= doy_full[8:0];
    end
    if (en[8]) begin
      d9_doy <= d8_doy;
      d9_mp  <= mp;
    end
    if (en[9]) begin
      res_q.year_number      <= year;
      res_q.month_of_year    <= mon;
      res_q.day_of_week      <= dow_q[8];
      res_q.month_day        <= dom_full[4:0];
      res_q.hour_of_day      <= hms_q[8].hour;
      res_q.minute_of_hour   <= hms_q[8].minute;
      res_q.second_of_minute <= hms_q[8].sec;
    end
  end

  assign out_data = res_q;

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (res_q.month_of_year != 4'd0) && (res_q.month_of_year <= MONTHS_PER_YEAR))
    else $error("month out of range");

  a_dom_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (res_q.month_day != 5'd0) && (res_q.day_of_week < DAYS_PER_WEEK))
    else $error("day of month or weekday out of range");

  a_year_range: assert property (@(posedge clk) disable iff (rst)
    vld[NSTG-1] |-> (res_q.year_number >= 11'd1970) && (res_q.year_number <= 11'd2038))
    else $error("year out of range");

endmodule

// ----- bench/epoch_seconds_to_calendar_test.sv -----
`timescale 1ns / 1ps

class calendar_scoreboard;
  localparam int unsigned SECS_IN_MINUTE = 60;
  localparam int unsigned SECS_IN_HOUR   = 3600;
  localparam int unsigned HOURS_IN_DAY   = 24;
  localparam int unsigned SECS_IN_DAY    = 86400;
  localparam int unsigned DAYS_IN_CYCLE  = 146097;  // one 400-year cycle
  localparam int unsigned MARCH_ZERO     = 719468;  // days from march-based day zero to the epoch
  localparam int unsigned THURSDAY       = 4;

  eptc_pkg::result_t due[$];
  int                failures;

  function new();
    failures = 0;
  endfunction

  task report(input string what);
    $display("mismatch: %s", what);
    failures++;
  endtask

  // calendar breakdown of one input word, bit 31 is ignored
  function eptc_pkg::result_t calendar_of(input logic [31:0] word);
    eptc_pkg::result_t r;
    int unsigned secs, day_count, sec_of_day, shifted, cycle_no, day_in_cycle;
    int unsigned year_in_cycle, day_in_year, month_idx, month_no;
    secs          = {1'b0, word[30:0]};
    day_count     = secs / SECS_IN_DAY;
    sec_of_day    = secs % SECS_IN_DAY;
    // years counted from march so that february falls last
    shifted       = day_count + MARCH_ZERO;
    cycle_no      = shifted / DAYS_IN_CYCLE;
    day_in_cycle  = shifted - cycle_no * DAYS_IN_CYCLE;
    year_in_cycle = (day_in_cycle - day_in_cycle / 1460 + day_in_cycle / 36524
                     - day_in_cycle / 146096) / 365;
    day_in_year   = day_in_cycle - (365 * year_in_cycle + year_in_cycle / 4
                                    - year_in_cycle / 100);
    month_idx     = (5 * day_in_year + 2) / 153;
    month_no      = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
    r.second_of_minute = 6'(sec_of_day % SECS_IN_MINUTE);
    r.minute_of_hour   = 6'((sec_of_day / SECS_IN_MINUTE) % SECS_IN_MINUTE);
    r.hour_of_day      = 5'((sec_of_day / SECS_IN_HOUR) % HOURS_IN_DAY);
    r.month_day        = 5'(day_in_year - (153 * month_idx + 2) / 5 + 1);
    r.day_of_week      = 3'((day_count + THURSDAY) % 7);
    r.month_of_year    = 4'(month_no);
    r.year_number      = 11'(year_in_cycle + cycle_no * 400 + ((month_no <= 2) ? 1 : 0));
    return r;
  endfunction

  function void note_input(input logic [31:0] word);
    due.push_back(calendar_of(word));
  endfunction

  function int waiting();
    return due.size();
  endfunction

  task check_result(input logic [39:0] data);
    eptc_pkg::result_t got, want;
    got = data;
    if (due.size() == 0) begin
      report($sformatf("unexpected transfer %h", data));
    end else begin
      want = due.pop_front();
      if (got.second_of_minute != want.second_of_minute)
        report($sformatf("second %0d, want %0d", got.second_of_minute, want.second_of_minute));
      if (got.minute_of_hour != want.minute_of_hour)
        report($sformatf("minute %0d, want %0d", got.minute_of_hour, want.minute_of_hour));
      if (got.hour_of_day != want.hour_of_day)
        report($sformatf("hour %0d, want %0d", got.hour_of_day, want.hour_of_day));
      if (got.month_day != want.month_day)
        report($sformatf("mday %0d, want %0d", got.month_day, want.month_day));
      if (got.day_of_week != want.day_of_week)
        report($sformatf("wday %0d, want %0d", got.day_of_week, want.day_of_week));
      if (got.month_of_year != want.month_of_year)
        report($sformatf("month %0d, want %0d", got.month_of_year, want.month_of_year));
      if (got.year_number != want.year_number)
        report($sformatf("year %0d, want %0d", got.year_number, want.year_number));
    end
  endtask
endclass

module epoch_seconds_to_calendar_test;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int ITEMS_PER_RUN = 600;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  int src_idle_pct = 0;
  int dst_idle_pct = 0;
  int cycles = 0;

  calendar_scoreboard book = new();

  epoch_seconds_to_calendar dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      book.check_result(m_axis_tdata);
  end

  // one transfer on the input side, valid stays up until the next call
  task automatic push_seconds(input logic [31:0] word);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk); while (!s_axis_tready);
    book.note_input(word);
  endtask

  task automatic hold_input();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (book.waiting() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_seconds();
    logic [31:0] word;
    int unsigned day_no;
    day_no = $urandom_range(24855);
    case ($urandom_range(3))
      0, 1: word = $urandom;
      // close to midnight on either side
      2: begin
        if (day_no > 0 && $urandom_range(1) == 1)
          word = day_no * 86400 - $urandom_range(1, 5);
        else
          word = day_no * 86400 + $urandom_range(0, 5);
      end
      // close to an hour or minute boundary
      default: word = day_no * 86400 + $urandom_range(23) * 3600
                      + $urandom_range(59) * 60 + ($urandom_range(1) ? 59 : 0);
    endcase
    word[31] = ($urandom_range(3) == 0);
    return word;
  endfunction

  initial begin
    logic [31:0] corners[$];
    corners = '{32'd0, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd68169600,     // leap day of 1972
                32'd94694399,     // last second of 1972
                32'd94694400,     // first second of 1973
                32'd946684799,    // last second of 1999
                32'd951782400,    // leap day of 2000, century leap year
                32'd951868800,    // first of march in 2000
                32'd983318400,    // end of february in 2001
                32'd2147472000,   // last midnight in range
                32'h7fffffff, 32'hffffffff, 32'h80000000,
                32'h55555555, 32'h2aaaaaaa};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corners[i]) push_seconds(corners[i]);
    hold_input();
    wait_drained();

    src_idle_pct = 8;
    dst_idle_pct = 52;
    repeat (ITEMS_PER_RUN) push_seconds(pick_seconds());
    // let the pipeline run dry before the rates change
    hold_input();
    wait_drained();

    src_idle_pct = 52;
    dst_idle_pct = 8;
    repeat (ITEMS_PER_RUN) push_seconds(pick_seconds());

    src_idle_pct = 0;
    dst_idle_pct = 0;
    repeat (ITEMS_PER_RUN) push_seconds(pick_seconds());
    hold_input();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.failures == 0 && book.waiting() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
hw/rtl/eptc_pkg.sv
hw/rtl/eptc_split.sv
hw/rtl/eptc_clock.sv
hw/rtl/eptc_date.sv
hw/rtl/epoch_seconds_to_calendar.sv
bench/epoch_seconds_to_calendar_test.sv
